/* design/phash_pkg.sv */
// shared types, character codes and hash step functions for the path hash block
package phash_pkg;

  localparam int HashWidth = 32;
  localparam int CharWidth = 8;

  localparam logic [CharWidth-1:0] NUL_CHAR       = 8'h00;
  localparam logic [CharWidth-1:0] QUOTE_CHAR     = 8'h22;
  localparam logic [CharWidth-1:0] BACKSLASH_CHAR = 8'h5C;
  localparam logic [CharWidth-1:0] SLASH_CHAR     = 8'h2F;
  localparam logic [CharWidth-1:0] UPPER_A        = 8'h41;
  localparam logic [CharWidth-1:0] UPPER_Z        = 8'h5A;
  localparam logic [CharWidth-1:0] CASE_OFFSET    = 8'd32;

  // one request as held in the input register
  typedef struct packed {
    logic [CharWidth-1:0] char_byte;
    logic                 start_req;
    logic [HashWidth-1:0] seed;
  } req_item_t;

  // input register contents handed to the core
  typedef struct packed {
    logic      valid;
    req_item_t item;
  } stage_t;

  // core to top: what the held request does this cycle
  typedef struct packed {
    logic                 take;
    logic                 emit;
    logic [HashWidth-1:0] hash;
  } step_t;

  function automatic logic [CharWidth-1:0] norm_char(input logic [CharWidth-1:0] b);
    logic [CharWidth-1:0] c;
    c = b;
    if (b inside {[UPPER_A:UPPER_Z]}) begin
      c = b + CASE_OFFSET;
    end else if (b == BACKSLASH_CHAR) begin
      c = SLASH_CHAR;
    end
    return c;
  endfunction

  function automatic logic [HashWidth-1:0] mix_char(input logic [HashWidth-1:0] h_in,
                                                    input logic [CharWidth-1:0] b);
    logic [CharWidth-1:0] c;
    logic [HashWidth-1:0] h;
    c = norm_char(b);
    h = h_in + {{(HashWidth-CharWidth){c[CharWidth-1]}}, c};
    h = h + (h << 10);
    h = h ^ (h >> 6);
    return h;
  endfunction

  function automatic logic [HashWidth-1:0] finish_hash(input logic [HashWidth-1:0] h_in);
    logic [HashWidth-1:0] h;
    h = h_in + (h_in << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

endpackage

/* design/phash_req_if.sv */
// request and result channel interfaces for the path hash block
interface phash_req_if
  import phash_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] char_byte;
  logic                 start_req;
  logic [HashWidth-1:0] seed;

  modport source (output valid, output char_byte, output start_req, output seed,
                  input ready);
  modport sink (input valid, input char_byte, input start_req, input seed,
                output ready);
endinterface

interface phash_res_if
  import phash_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [HashWidth-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

/* design/path_hash_one_at_a_time_unit.sv */
// an accepted request is held in the input register; a string end loads the result register
// throughput: one request per cycle when no end stalls (one mix step on the running hash)
// requests that end no string pass even while a result waits on the output
// a request that ends a string waits in the input register until the result register frees
// reset (synchronous, active high) clears both valid flags and leaves the block waiting
// for a start request, with a zero running hash and quoted mode off
module path_hash_one_at_a_time_unit
  import phash_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  phash_req_if.sink  req,
  phash_res_if.source res
);

  stage_t stage;
  step_t  step;
  logic   out_free;

  // result register: holds one finished hash until the sink takes it
  logic                 res_valid;
  logic [HashWidth-1:0] res_hash;

  // room in the result register this cycle, counting a take by the sink
  assign out_free = !res_valid || res.ready;

  phash_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .take  (step.take),
    .stage (stage)
  );

  phash_core u_core (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .out_free (out_free),
    .step     (step)
  );

  // load a new result, or drop the old one once the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step.emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.emit) begin
      res_hash <= step.hash;
    end
  end

  assign res.valid      = res_valid;
  assign res.hash_value = res_hash;

endmodule

/* design/phash_in_stage.sv */
// input register holding one request ahead of the hash core
module phash_in_stage
  import phash_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  phash_req_if.sink       req,
  input  logic            take,
  output stage_t          stage
);

  logic      held_valid;
  req_item_t held_item;

  assign req.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      held_item.char_byte <= req.char_byte;
      held_item.start_req <= req.start_req;
      held_item.seed      <= req.seed;
    end
  end

  assign stage.valid = held_valid;
  assign stage.item  = held_item;

endmodule

/* design/phash_core.sv */
// string state registers with the per-byte mix and the final avalanche
module phash_core
  import phash_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  stage_t stage,
  input  logic   out_free,
  output step_t  step
);

  logic [HashWidth-1:0] running_hash;
  logic [HashWidth-1:0] running_hash_next;
  logic                 quoted_mode;
  logic                 quoted_mode_next;
  logic                 string_ended;
  logic                 string_ended_next;

  logic                 active;
  logic                 open_quote;
  logic                 quoted_eff;
  logic                 ends;
  logic                 go;
  logic [HashWidth-1:0] hash_base;
  logic [CharWidth-1:0] b;

  always_comb begin
    b          = stage.item.char_byte;
    active     = stage.item.start_req || !string_ended;
    open_quote = stage.item.start_req && (b == QUOTE_CHAR);
    quoted_eff = !stage.item.start_req && quoted_mode;
    ends       = active && !open_quote &&
                 ((b == NUL_CHAR) || (quoted_eff && (b == QUOTE_CHAR)));
    hash_base  = stage.item.start_req ? stage.item.seed : running_hash;
    go         = stage.valid && (!ends || out_free);
  end

  always_comb begin
    running_hash_next = running_hash;
    quoted_mode_next  = quoted_mode;
    string_ended_next = string_ended;
    if (go && active) begin
      if (open_quote) begin
        running_hash_next = hash_base;
        quoted_mode_next  = 1'b1;
        string_ended_next = 1'b0;
      end else if (ends) begin
        running_hash_next = hash_base;
        quoted_mode_next  = 1'b0;
        string_ended_next = 1'b1;
      end else begin
        running_hash_next = mix_char(hash_base, b);
        quoted_mode_next  = quoted_eff;
        string_ended_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      quoted_mode  <= 1'b0;
      string_ended <= 1'b1;
    end else begin
      running_hash <= running_hash_next;
      quoted_mode  <= quoted_mode_next;
      string_ended <= string_ended_next;
    end
  end

  assign step.take = go;
  assign step.emit = go && ends;
  assign step.hash = finish_hash(hash_base);

`ifndef SYNTHESIS
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    step.emit |=> string_ended && !quoted_mode)
    else $error("string not closed after its result");

  a_no_take_empty: assert property (@(posedge clk) disable iff (rst)
    !stage.valid |-> !step.take)
    else $error("core took an empty input register");

  a_open_quote: assert property (@(posedge clk) disable iff (rst)
    (step.take && open_quote) |=> quoted_mode && !string_ended)
    else $error("opening quote did not enter quoted mode");
`endif

endmodule
